// File: hw/rtl/gbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants of the two-pass 3x3 Gaussian blur
// Register map, input op codes, queue depths and the control bundle that
// travels with every item from the front end to the filter passes.
// ----------------------------------------------------------------------------
package gbt_pkg;

    // Default line buffer depth (widest supported frame)
    localparam int MAX_WIDTH_DEF = 2048;

    // Queue between the front end and the filter passes
    localparam int MID_DEPTH = 4;
    // Result queue; also bounds the number of results in flight
    localparam int OUT_DEPTH = 16;

    // Configuration reset values
    localparam logic [11:0] CFG_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] CFG_HEIGHT_RESET = 16'd480;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Border position of the window center
    typedef struct packed {
        logic x_first;
        logic x_last;
        logic y_first;
        logic y_last;
    } t_edge;

    // Per-item control from the front end
    typedef struct packed {
        logic  p2_step;    // item advances pass two
        t_edge e1;         // border flags of the pass one center
        t_edge e2;         // border flags of the pass two center
        logic  out_valid;  // item yields a result
        logic  last;       // result is the final pixel of the frame
    } t_ctrl;

endpackage

// File: hw/rtl/gaussian_blur_3x3_two_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_two_pass: cascaded 3x3 Gaussian blur, replicated borders
// Raster-order 8-bit pixel stream in, twice-blurred stream out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive op/pixel_in with push; an item is taken when push is
//   high and full is low. A frame starts with its first pixel; frame width
//   and height are latched then. Flush items (op = 1) after the frame drain
//   the 2*(width+1) pixels still held; flushes before or inside a frame are
//   dropped. Pixels offered during the drain count as flushes.
//   Result queue: the oldest result is on pixel_out/frame_last while empty is
//   low; pop takes it. frame_last marks the final pixel of the frame.
//   Throughput: one item per clock while full is low. Each item passes a
//   small input queue and two four-stage filter pipelines, each with two
//   single-port line buffers of MAX_WIDTH pixels.
//   When pop stalls, up to 16 results are buffered; beyond that full rises.
//   Reset: synchronous, clears all queues and counters and sets the frame
//   to 640 x 480. Line buffers are not cleared and need no sweep.
//   Configuration: write only while idle; takes effect at the next frame.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_two_pass #(
    parameter int MAX_WIDTH = gbt_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_pixel_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_pixel_out,
    output logic        o_frame_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CTW = $bits(gbt_pkg::t_ctrl);
    localparam int MQW = CTW + 2 * AW + 8;
    localparam int SW1 = 1 + $bits(gbt_pkg::t_edge) + AW + 2;
    localparam int SW2 = 2;
    localparam int OCW = $clog2(gbt_pkg::OUT_DEPTH + 1);

    logic           fq_push;
    logic [7:0]     fq_pix;
    logic [AW-1:0]  fq_ptr1, fq_ptr2;
    gbt_pkg::t_ctrl fq_ctrl;

    logic           mq_full, mq_empty, mq_pop;
    logic [MQW-1:0] mq_data;
    logic [7:0]     mq_pix;
    logic [AW-1:0]  mq_ptr1, mq_ptr2;
    gbt_pkg::t_ctrl mq_ctrl;

    logic           p1_valid, p2_valid;
    logic [7:0]     p1_pix, p2_pix;
    logic [SW1-1:0] p1_side;
    logic [SW2-1:0] p2_side;
    logic           p1_step, p1_outv, p1_last;
    gbt_pkg::t_edge p1_e2;
    logic [AW-1:0]  p1_ptr2;

    logic           oq_push, oq_full;
    logic [8:0]     oq_data;
    logic [OCW-1:0] r_pending;

    gbt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (i_op),
        .i_pixel_in (i_pixel_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (mq_full),
        .o_q_push   (fq_push),
        .o_q_pix    (fq_pix),
        .o_q_ptr1   (fq_ptr1),
        .o_q_ptr2   (fq_ptr2),
        .o_q_ctrl   (fq_ctrl)
    );

    assign full = mq_full;

    gbt_fifo #(.WIDTH(MQW), .DEPTH(gbt_pkg::MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  ({fq_ctrl, fq_ptr2, fq_ptr1, fq_pix}),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_data  (mq_data),
        .o_empty (mq_empty)
    );

    assign {mq_ctrl, mq_ptr2, mq_ptr1, mq_pix} = mq_data;

    // Issue only while the result queue has room for every result in flight
    assign mq_pop = !mq_empty &&
                    (!mq_ctrl.out_valid || (r_pending < OCW'(gbt_pkg::OUT_DEPTH)));

    // Track results issued but not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({mq_pop && mq_ctrl.out_valid, pop && !empty})
                2'b10:   r_pending <= r_pending + OCW'(1);
                2'b01:   r_pending <= r_pending - OCW'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

    gbt_pass #(.MAX_WIDTH(MAX_WIDTH), .SW(SW1)) u_pass_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mq_pop),
        .i_pix   (mq_pix),
        .i_ptr   (mq_ptr1),
        .i_edge  (mq_ctrl.e1),
        .i_side  ({mq_ctrl.p2_step, mq_ctrl.e2, mq_ptr2, mq_ctrl.out_valid, mq_ctrl.last}),
        .o_valid (p1_valid),
        .o_pix   (p1_pix),
        .o_side  (p1_side)
    );

    assign {p1_step, p1_e2, p1_ptr2, p1_outv, p1_last} = p1_side;

    gbt_pass #(.MAX_WIDTH(MAX_WIDTH), .SW(SW2)) u_pass_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p1_valid && p1_step),
        .i_pix   (p1_pix),
        .i_ptr   (p1_ptr2),
        .i_edge  (p1_e2),
        .i_side  ({p1_outv, p1_last}),
        .o_valid (p2_valid),
        .o_pix   (p2_pix),
        .o_side  (p2_side)
    );

    assign oq_push = p2_valid && p2_side[1];

    gbt_fifo #(.WIDTH(9), .DEPTH(gbt_pkg::OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  ({p2_side[0], p2_pix}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_data),
        .o_empty (empty)
    );

    assign {o_frame_last, o_pixel_out} = oq_data;

`ifndef SYNTHESIS
    // Credit scheme must keep the result queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(oq_push && oq_full))
        else $error("result queue overflow");

    // Results in flight never exceed the result queue depth
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= OCW'(gbt_pkg::OUT_DEPTH))
        else $error("pending result count out of range");

    // Nothing outstanding means nothing waiting
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> empty)
        else $error("result present with no pending count");
`endif

endmodule

// File: hw/rtl/gbt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_fifo: small register queue
// Power-of-two depth, head entry visible on the read side while not empty.
// ----------------------------------------------------------------------------
module gbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + PW'(1);
            if (rd_en) r_rd <= r_rd + PW'(1);
            if (wr_en && !rd_en) r_cnt <= r_cnt + CW'(1);
            else if (rd_en && !wr_en) r_cnt <= r_cnt - CW'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_data;
    end

endmodule

// File: hw/rtl/gbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_front: frame tracking and item classification
// Holds the configuration, latches the frame size at the first pixel, drops
// bubbles and tags each item with line buffer pointers and border flags for
// both passes.
// ----------------------------------------------------------------------------
module gbt_front #(
    parameter int MAX_WIDTH = gbt_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_op,
    input  logic [7:0]           i_pixel_in,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output logic [7:0]           o_q_pix,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_q_ptr1,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_q_ptr2,
    output gbt_pkg::t_ctrl       o_q_ctrl
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = $clog2(MAX_WIDTH + 2);

    logic [11:0]   r_cfg_w;
    logic [15:0]   r_cfg_h;
    logic          r_busy, n_busy;
    logic [WW-1:0] r_aw, n_aw;
    logic [15:0]   r_ah, n_ah;
    logic [AW-1:0] r_xc, n_xc, r_xm, n_xm, r_xo, n_xo;
    logic [15:0]   r_yc, n_yc, r_ym, n_ym, r_yo, n_yo;
    logic [LW-1:0] r_clag, n_clag, r_mlag, n_mlag;

    logic [WW-1:0] w_clamp, aw;
    logic [15:0]   h_clamp, ah;
    logic [LW-1:0] lag;
    logic          in_frame, bubble, step, m_act, o_act;
    logic          xc_wrap, xm_wrap, xo_wrap, out_valid, last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= gbt_pkg::CFG_WIDTH_RESET;
            r_cfg_h <= gbt_pkg::CFG_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (gbt_pkg::t_cfg_reg'(i_cfg_addr))
                gbt_pkg::CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[11:0];
                gbt_pkg::CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bound the frame size: zero means one, width saturates at the buffer depth
    always_comb begin
        if (r_cfg_w == '0) w_clamp = WW'(1);
        else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) w_clamp = WW'(MAX_WIDTH);
        else w_clamp = WW'(r_cfg_w);
        h_clamp = (r_cfg_h == '0) ? 16'd1 : r_cfg_h;
    end

    // Classify the offered item and work out counter updates
    always_comb begin
        aw        = r_busy ? r_aw : w_clamp;
        ah        = r_busy ? r_ah : h_clamp;
        lag       = LW'(aw) + LW'(1);
        in_frame  = (r_yc < ah);
        bubble    = (i_op == gbt_pkg::OP_FLUSH) && in_frame;
        step      = i_push && !i_q_full && !bubble;
        m_act     = (r_clag == lag);
        o_act     = m_act && (r_mlag == lag);
        xc_wrap   = (WW'(r_xc) == aw - WW'(1));
        xm_wrap   = (WW'(r_xm) == aw - WW'(1));
        xo_wrap   = (WW'(r_xo) == aw - WW'(1));
        out_valid = o_act && (r_yo < ah);
        last      = out_valid && xo_wrap && (r_yo == ah - 16'd1);

        n_busy = r_busy;
        n_aw   = r_aw;
        n_ah   = r_ah;
        n_xc   = r_xc;
        n_yc   = r_yc;
        n_xm   = r_xm;
        n_ym   = r_ym;
        n_xo   = r_xo;
        n_yo   = r_yo;
        n_clag = r_clag;
        n_mlag = r_mlag;

        if (step) begin
            n_busy = 1'b1;
            n_aw   = aw;
            n_ah   = ah;
            n_xc   = xc_wrap ? '0 : r_xc + AW'(1);
            if (xc_wrap && in_frame) n_yc = r_yc + 16'd1;
            if (!m_act) n_clag = r_clag + LW'(1);
            if (m_act) begin
                n_xm = xm_wrap ? '0 : r_xm + AW'(1);
                if (xm_wrap && (r_ym < ah)) n_ym = r_ym + 16'd1;
                if (!o_act) n_mlag = r_mlag + LW'(1);
            end
            if (o_act) begin
                n_xo = xo_wrap ? '0 : r_xo + AW'(1);
                if (xo_wrap && (r_yo < ah)) n_yo = r_yo + 16'd1;
            end
            // Frame done: return to the start state
            if (last) begin
                n_busy = 1'b0;
                n_xc   = '0;
                n_yc   = '0;
                n_xm   = '0;
                n_ym   = '0;
                n_xo   = '0;
                n_yo   = '0;
                n_clag = '0;
                n_mlag = '0;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_aw   <= WW'(1);
            r_ah   <= 16'd1;
            r_xc   <= '0;
            r_yc   <= '0;
            r_xm   <= '0;
            r_ym   <= '0;
            r_xo   <= '0;
            r_yo   <= '0;
            r_clag <= '0;
            r_mlag <= '0;
        end else begin
            r_busy <= n_busy;
            r_aw   <= n_aw;
            r_ah   <= n_ah;
            r_xc   <= n_xc;
            r_yc   <= n_yc;
            r_xm   <= n_xm;
            r_ym   <= n_ym;
            r_xo   <= n_xo;
            r_yo   <= n_yo;
            r_clag <= n_clag;
            r_mlag <= n_mlag;
        end
    end

    // Tag the item
    always_comb begin
        o_q_push                   = step;
        o_q_pix                    = i_pixel_in;
        o_q_ptr1                   = r_xc;
        o_q_ptr2                   = r_xm;
        o_q_ctrl.p2_step           = m_act;
        o_q_ctrl.e1.x_first        = (r_xm == '0);
        o_q_ctrl.e1.x_last         = xm_wrap;
        o_q_ctrl.e1.y_first        = (r_ym == '0);
        o_q_ctrl.e1.y_last         = (r_ym == ah - 16'd1);
        o_q_ctrl.e2.x_first        = (r_xo == '0);
        o_q_ctrl.e2.x_last         = xo_wrap;
        o_q_ctrl.e2.y_first        = (r_yo == '0);
        o_q_ctrl.e2.y_last         = (r_yo == ah - 16'd1);
        o_q_ctrl.out_valid         = out_valid;
        o_q_ctrl.last              = last;
    end

endmodule

// File: hw/rtl/gbt_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_pass: one 3x3 Gaussian pass
// Two line buffers feed a 3x3 window; border taps are replaced by the
// center row or column, and the weighted sum is rounded to 8 bits.
// Four-stage pipeline, one item per cycle, sideband carried alongside.
// ----------------------------------------------------------------------------
module gbt_pass #(
    parameter int MAX_WIDTH = gbt_pkg::MAX_WIDTH_DEF,
    parameter int SW        = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_pix,
    input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] i_ptr,
    input  gbt_pkg::t_edge       i_edge,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [7:0]           o_pix,
    output logic [SW-1:0]        o_side
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [7:0]     r_line1 [MAX_WIDTH];
    logic [7:0]     r_line2 [MAX_WIDTH];

    logic           r_s1_valid, r_s2_valid, r_s3_valid;
    logic [7:0]     r_s1_pix, r_s2_pix, r_rd1, r_s2_rd1, r_rd2;
    logic [AW-1:0]  r_s1_ptr;
    gbt_pkg::t_edge r_s1_edge, r_s2_edge, r_s3_edge;
    logic [SW-1:0]  r_s1_side, r_s2_side, r_s3_side;
    logic [7:0]     r_win [3][3];

    logic [7:0]     tap_l, tap_c, tap_r;
    logic [9:0]     row_sum [3];
    logic [11:0]    sum;
    int             src;

    // Stage 1: first line buffer, read before write
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd1            <= r_line1[i_ptr];
            r_line1[i_ptr]   <= i_pix;
        end
    end

    // Stage 2: second line buffer takes the first one's output
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_rd2              <= r_line2[r_s1_ptr];
            r_line2[r_s1_ptr]  <= r_rd1;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_pix  <= i_pix;
            r_s1_ptr  <= i_ptr;
            r_s1_edge <= i_edge;
            r_s1_side <= i_side;
        end
        if (r_s1_valid) begin
            r_s2_pix  <= r_s1_pix;
            r_s2_rd1  <= r_rd1;
            r_s2_edge <= r_s1_edge;
            r_s2_side <= r_s1_side;
        end
        if (r_s2_valid) begin
            r_s3_edge <= r_s2_edge;
            r_s3_side <= r_s2_side;
        end
        if (r_s3_valid) begin
            o_pix  <= 8'((sum + 12'd8) >> 4);
            o_side <= r_s3_side;
        end
    end

    // Stage 3: shift a new column into the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) r_win[r][k] <= '0;
            end
        end else if (r_s2_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_rd2;
            r_win[1][2] <= r_s2_rd1;
            r_win[2][2] <= r_s2_pix;
        end
    end

    // Stage 4: replicate borders and form the weighted sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            src = r;
            if ((r == 0 && r_s3_edge.y_first) || (r == 2 && r_s3_edge.y_last)) src = 1;
            tap_c      = r_win[src][1];
            tap_l      = r_s3_edge.x_first ? tap_c : r_win[src][0];
            tap_r      = r_s3_edge.x_last  ? tap_c : r_win[src][2];
            row_sum[r] = {2'b00, tap_l} + {1'b0, tap_c, 1'b0} + {2'b00, tap_r};
        end
        sum = {2'b00, row_sum[0]} + {1'b0, row_sum[1], 1'b0} + {2'b00, row_sum[2]};
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            o_valid    <= r_s3_valid;
        end
    end

endmodule

// File: test/tb_gaussian_blur_3x3_two_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_two_pass: self-checking bench of the two-pass blur
// Streams frames of many sizes with random idle gaps on both queues.
// A behavioral copy of the cascaded 3x3 filter predicts every output pixel.
// Each popped pixel is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_two_pass;

    localparam int MAXW       = gbt_pkg::MAX_WIDTH_DEF;
    localparam int RING_DEPTH = 2 * MAXW + 3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_ITEMS = 700;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } t_blur_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_op = gbt_pkg::OP_PIXEL;
    logic [7:0]  i_pixel_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_pixel_out;
    logic        o_frame_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_data = '0;

    gaussian_blur_3x3_two_pass dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_op(i_op), .i_pixel_in(i_pixel_in),
        .empty(empty), .pop(pop), .o_pixel_out(o_pixel_out),
        .o_frame_last(o_frame_last),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    // Shadow of the filter state
    logic [11:0] cfg_width;
    logic [15:0] cfg_height;
    logic [7:0]  pass1_ring [RING_DEPTH];
    logic [7:0]  pass2_ring [RING_DEPTH];
    int unsigned in_pos;
    int unsigned act_w;
    int unsigned act_h;
    t_blur_res   pending_pixels [$];

    int  err_count = 0;
    int  taken_items = 0;
    int  frames_done = 0;
    int  pixels_checked = 0;
    int  cycle_count = 0;
    bit  no_gaps = 1'b0;
    bit  rst_done = 1'b0;

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Guard against a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gaussian_blur_3x3_two_pass test failed");
            $finish;
        end
    end

    // One 3x3 pass at raster position pos, borders clamped
    function automatic logic [7:0] blur_at(bit second, int unsigned pos);
        int unsigned y, x, sum, wy, wx, idx;
        int ry, rx;
        y   = pos / act_w;
        x   = pos % act_w;
        sum = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            ry = int'(y) + dy;
            if (ry < 0) ry = 0;
            if (ry > int'(act_h) - 1) ry = int'(act_h) - 1;
            wy = (dy == 0) ? 2 : 1;
            for (int dx = -1; dx <= 1; dx++) begin
                rx = int'(x) + dx;
                if (rx < 0) rx = 0;
                if (rx > int'(act_w) - 1) rx = int'(act_w) - 1;
                wx  = (dx == 0) ? 2 : 1;
                idx = (ry * act_w + rx) % RING_DEPTH;
                sum += wy * wx * (second ? pass2_ring[idx] : pass1_ring[idx]);
            end
        end
        return 8'((sum + 8) >> 4);
    endfunction

    // Advance the shadow filter by one accepted item
    task automatic blur_step(logic op, logic [7:0] pix);
        int unsigned total, c, lag, m, o;
        t_blur_res r;
        if (in_pos == 0) begin
            // drop bubbles ahead of a frame, latch geometry on its first pixel
            if (op == gbt_pkg::OP_FLUSH) return;
            act_w = (cfg_width == 0) ? 1 : cfg_width;
            if (act_w > MAXW) act_w = MAXW;
            act_h = (cfg_height == 0) ? 1 : cfg_height;
        end
        total = act_w * act_h;
        lag   = act_w + 1;
        if (in_pos < total) begin
            if (op == gbt_pkg::OP_FLUSH) return;
            pass1_ring[in_pos % RING_DEPTH] = pix;
        end
        taken_items++;
        c = in_pos;
        in_pos++;
        if (c >= lag) begin
            m = c - lag;
            if (m < total) pass2_ring[m % RING_DEPTH] = blur_at(1'b0, m);
            if (m >= lag) begin
                o = m - lag;
                if (o < total) begin
                    r.pix  = blur_at(1'b1, o);
                    r.last = (o == total - 1);
                    pending_pixels.push_back(r);
                    if (r.last) begin
                        in_pos = 0;
                        frames_done++;
                    end
                end
            end
        end
    endtask

    // Offer one item after a random gap; returns at the accepting edge
    task automatic send_item(logic op, logic [7:0] pix);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_op       <= op;
        i_pixel_in <= pix;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        blur_step(op, pix);
    endtask

    // Drop push and wait until the block has drained
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Hold the write enable high; the caller drops it after the last write
    task automatic cfg_write(gbt_pkg::t_cfg_reg idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == gbt_pkg::CFG_FRAME_WIDTH) cfg_width = data[11:0];
        else cfg_height = data;
    endtask

    // One whole frame plus its drain; fill: 0 random, 1 all 0, 2 all 255, 3 checker
    task automatic run_frame(logic [15:0] w_reg, logic [15:0] h_reg, int fill,
                             bit noisy);
        int unsigned w, h;
        logic [7:0] p;
        settle();
        cfg_write(gbt_pkg::CFG_FRAME_WIDTH, w_reg);
        cfg_write(gbt_pkg::CFG_FRAME_HEIGHT, h_reg);
        i_cfg_we <= 1'b0;
        w = (cfg_width == 0) ? 1 : cfg_width;
        if (w > MAXW) w = MAXW;
        h = (cfg_height == 0) ? 1 : cfg_height;
        if (noisy) repeat ($urandom_range(1, 2)) send_item(gbt_pkg::OP_FLUSH, 8'($urandom));
        for (int unsigned i = 0; i < w * h; i++) begin
            // flush bubbles inside the frame
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(gbt_pkg::OP_FLUSH, 8'($urandom));
            case (fill)
                1: p = 8'h00;
                2: p = 8'hFF;
                3: p = ((i % w + i / w) % 2) ? 8'hFF : 8'h00;
                default: p = 8'($urandom);
            endcase
            send_item(gbt_pkg::OP_PIXEL, p);
        end
        // drain; pixels offered here count as flushes
        for (int unsigned i = 0; i < 2 * (w + 1); i++) begin
            if (noisy && $urandom_range(0, 1)) send_item(gbt_pkg::OP_PIXEL, 8'($urandom));
            else send_item(gbt_pkg::OP_FLUSH, 8'($urandom));
        end
    endtask

    // Result side: random pop gaps, compare against oldest prediction
    initial begin
        int gap;
        t_blur_res want;
        logic [7:0] got_pix;
        logic got_last;
        wait (rst_done);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(negedge i_clk);
            while (empty) @(negedge i_clk);
            got_pix  = o_pixel_out;
            got_last = o_frame_last;
            @(posedge i_clk);
            if (pending_pixels.size() == 0) begin
                $error("unexpected item: pixel_out %0d frame_last %0b", got_pix, got_last);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got_pix !== want.pix) begin
                    $error("pixel_out: expected %0d, got %0d", want.pix, got_pix);
                    err_count++;
                end
                if (got_last !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, got_last);
                    err_count++;
                end
            end
        end
    end

    task automatic test_tiny_frames();
        run_frame(16'd0, 16'd0, 0, 1'b0);   // zero sizes act as one
        run_frame(16'd1, 16'd1, 2, 1'b0);
        run_frame(16'd1, 16'd3, 0, 1'b0);
        run_frame(16'd3, 16'd1, 0, 1'b0);
    endtask

    task automatic test_pixel_extremes();
        run_frame(16'd4, 16'd3, 1, 1'b0);
        run_frame(16'd4, 16'd3, 2, 1'b0);
        run_frame(16'd3, 16'd3, 3, 1'b0);
    endtask

    task automatic test_bubbles_and_drain_pixels();
        run_frame(16'd3, 16'd2, 0, 1'b1);
        run_frame(16'd2, 16'd2, 0, 1'b1);
    endtask

    task automatic test_width_field_masking();
        no_gaps = 1'b1;
        run_frame(16'h1010, 16'd2, 0, 1'b0);   // only the low 12 bits count
        no_gaps = 1'b0;
    endtask

    task automatic test_tall_narrow_frame();
        no_gaps = 1'b1;
        run_frame(16'd1, 16'd64, 0, 1'b0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        int start;
        start = taken_items;
        while (taken_items - start < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            run_frame(16'($urandom_range(1, 9)), 16'($urandom_range(1, 6)),
                      ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                      $urandom_range(0, 3) == 0);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        cfg_width  = gbt_pkg::CFG_WIDTH_RESET;
        cfg_height = gbt_pkg::CFG_HEIGHT_RESET;
        in_pos = 0;
        act_w  = 1;
        act_h  = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        test_tiny_frames();
        test_pixel_extremes();
        test_bubbles_and_drain_pixels();
        test_width_field_masking();
        test_tall_narrow_frame();
        test_random_frames();

        settle();
        $display("Covered %0d frames, %0d state-changing items, %0d pixels checked.",
                 frames_done, taken_items, pixels_checked);
        $display("Sizes from 1x1 up to 16 columns and 64 rows, with bubbles and stalls.");
        if (err_count == 0) begin
            $display("gaussian_blur_3x3_two_pass test passed");
        end else begin
            $display("gaussian_blur_3x3_two_pass test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/gbt_pkg.sv
hw/rtl/gbt_fifo.sv
hw/rtl/gbt_front.sv
hw/rtl/gbt_pass.sv
hw/rtl/gaussian_blur_3x3_two_pass.sv
test/tb_gaussian_blur_3x3_two_pass.sv
